FILE: hdl/longest_repeat_run_tracker_macros.svh
// Assertion helpers shared by the tracker modules.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef LONGEST_REPEAT_RUN_TRACKER_MACROS_SVH
`define LONGEST_REPEAT_RUN_TRACKER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LRT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication, checked out of reset
`define LRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

FILE: hdl/lrt_pkg.sv
`timescale 1ns / 1ps

package lrt_pkg;

  localparam int LEN_W          = 11;
  localparam int POS_W          = 10;
  localparam int SYM_W          = 8;
  localparam int MAX_LENGTH_DEF = 1024;

  // One tree node: run lengths and edge symbols of its interval
  typedef struct packed {
    logic [LEN_W-1:0] run;
    logic [LEN_W-1:0] head_run;
    logic [LEN_W-1:0] tail_run;
    logic [SYM_W-1:0] head_sym;
    logic [SYM_W-1:0] tail_sym;
  } lrt_node_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture word, set up descent at root
    logic step;   // descend one level, push interval length
    logic leaf;   // write the leaf node
    logic rd;     // move to parent, read both children
    logic wr;     // merge children, write parent
  } lrt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pos_ok;   // incoming position below length
    logic at_leaf;  // current interval holds one character
    logic at_root;  // path stack empty
    logic func;     // captured word wants a result
  } lrt_sts_t;

endpackage

FILE: hdl/lrt_dp.sv
`timescale 1ns / 1ps

module lrt_dp #(
  parameter int MAX_LENGTH = lrt_pkg::MAX_LENGTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [lrt_pkg::LEN_W-1:0] cfg_length,
  input  logic                    in_func,
  input  logic [lrt_pkg::POS_W-1:0] in_position,
  input  logic [lrt_pkg::SYM_W-1:0] in_symbol,
  input  lrt_pkg::lrt_cmd_t       cmd,
  output lrt_pkg::lrt_sts_t       sts,
  output logic [lrt_pkg::LEN_W-1:0] out_longest_run
);
  import lrt_pkg::*;

  localparam int TREE_SIZE = 4 * MAX_LENGTH;
  localparam int NODE_W    = $clog2(TREE_SIZE);
  localparam int DEPTH     = $clog2(MAX_LENGTH);
  localparam int LVL_W     = $clog2(DEPTH + 1);
  localparam int SIDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Merge rule for two adjacent intervals
  function automatic lrt_node_t combine(lrt_node_t a, lrt_node_t b,
                                        logic [LEN_W-1:0] a_len,
                                        logic [LEN_W-1:0] b_len);
    lrt_node_t        r;
    logic [LEN_W-1:0] joined;
    joined     = a.tail_run + b.head_run;
    r.head_sym = a.head_sym;
    r.tail_sym = b.tail_sym;
    r.run      = (a.run > b.run) ? a.run : b.run;
    if ((a.tail_sym == b.head_sym) && (joined > r.run)) begin
      r.run = joined;
    end
    if ((a.head_run == a_len) && (a.head_sym == b.head_sym)) begin
      r.head_run = a.head_run + b.head_run;
    end else begin
      r.head_run = a.head_run;
    end
    if ((b.tail_run == b_len) && (b.tail_sym == a.tail_sym)) begin
      r.tail_run = b.tail_run + a.tail_run;
    end else begin
      r.tail_run = b.tail_run;
    end
    return r;
  endfunction

  lrt_node_t        mem [TREE_SIZE];
  lrt_node_t        rd_a_r, rd_b_r;
  logic [LEN_W-1:0] stk_r [DEPTH];

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LVL_W-1:0]  lvl_r;
  logic [NODE_W-1:0] node_r;
  logic [LEN_W-1:0]  lo_r, n_r, res_r;
  logic [POS_W-1:0]  pos_r;
  logic [SYM_W-1:0]  sym_r;
  logic              func_r;

  logic [LEN_W-1:0]  half_l, half_r, rel, cur_len, a_len, b_len;
  logic [NODE_W-1:0] parent;
  lrt_node_t         merged, leaf_node;

  // Length register with range clamp
  always_comb begin
    len_nxt = cfg_length;
    if (cfg_length == '0) begin
      len_nxt = LEN_W'(1);
    end else if (32'(cfg_length) > 32'(MAX_LENGTH)) begin
      len_nxt = LEN_W'(MAX_LENGTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      len_r <= len_nxt;
    end
  end

  // Descent arithmetic: left child takes the larger half of an odd interval
  assign half_l  = LEN_W'(({1'b0, n_r} + (LEN_W + 1)'(1)) >> 1);
  assign half_r  = n_r >> 1;
  assign rel     = LEN_W'(pos_r) - lo_r;
  assign parent  = node_r >> 1;

  // Merge inputs for the parent at the current level
  assign cur_len = stk_r[lvl_r[SIDX_W-1:0]];
  assign a_len   = LEN_W'(({1'b0, cur_len} + (LEN_W + 1)'(1)) >> 1);
  assign b_len   = cur_len >> 1;
  assign merged  = combine(rd_a_r, rd_b_r, a_len, b_len);

  always_comb begin
    leaf_node          = '0;
    leaf_node.run      = LEN_W'(1);
    leaf_node.head_run = LEN_W'(1);
    leaf_node.tail_run = LEN_W'(1);
    leaf_node.head_sym = sym_r;
    leaf_node.tail_sym = sym_r;
  end

  // Path walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
    end else if (cmd.load) begin
      lvl_r <= '0;
    end else if (cmd.step) begin
      lvl_r <= lvl_r + LVL_W'(1);
    end else if (cmd.rd) begin
      lvl_r <= lvl_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      pos_r  <= in_position;
      sym_r  <= in_symbol;
      node_r <= NODE_W'(1);
      lo_r   <= '0;
      n_r    <= len_r;
    end else if (cmd.step) begin
      stk_r[lvl_r[SIDX_W-1:0]] <= n_r;
      if (rel < half_l) begin
        node_r <= {node_r[NODE_W-2:0], 1'b0};
        n_r    <= half_l;
      end else begin
        node_r <= {node_r[NODE_W-2:0], 1'b1};
        lo_r   <= lo_r + half_l;
        n_r    <= half_r;
      end
    end else if (cmd.rd) begin
      node_r <= parent;
    end
  end

  // Node store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.leaf) begin
      mem[node_r] <= leaf_node;
    end else if (cmd.wr) begin
      mem[node_r] <= merged;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[{parent[NODE_W-2:0], 1'b0}];
      rd_b_r <= mem[{parent[NODE_W-2:0], 1'b1}];
    end
  end

  // Latest root candidate
  always_ff @(posedge clk) begin
    if (cmd.leaf) begin
      res_r <= LEN_W'(1);
    end else if (cmd.wr) begin
      res_r <= merged.run;
    end
  end

  assign out_longest_run = res_r;

  assign sts.pos_ok  = ({1'b0, in_position} < len_r);
  assign sts.at_leaf = (n_r == LEN_W'(1));
  assign sts.at_root = (lvl_r == '0);
  assign sts.func    = func_r;

`include "longest_repeat_run_tracker_macros.svh"

  `LRT_ASSERT_SAME(a_step_not_leaf, cmd.step, n_r > LEN_W'(1))
  `LRT_ASSERT_NEXT(a_root_write_ends_at_root, cmd.wr && (lvl_r == '0), node_r == NODE_W'(1))
  `LRT_ASSERT_SAME(a_stack_bound, 1'b1, 32'(lvl_r) <= 32'(DEPTH))

endmodule

FILE: hdl/lrt_ctrl.sv
`timescale 1ns / 1ps

module lrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lrt_pkg::lrt_sts_t sts,
  output lrt_pkg::lrt_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import lrt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DESC,
    ST_RD,
    ST_WR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy_r && sts.pos_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DESC;
        end
      end
      ST_DESC: begin
        if (sts.at_leaf) begin
          cmd.leaf = 1'b1;
          if (sts.at_root) begin
            out_valid_nxt = sts.func;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_RD;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.at_root) begin
          out_valid_nxt = sts.func;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

`include "longest_repeat_run_tracker_macros.svh"

  `LRT_ASSERT_SAME(a_strobe_when_idle, out_valid_r, !busy_r && (state_r == ST_IDLE))
  `LRT_ASSERT_NEXT(a_rd_then_wr, state_r == ST_RD, state_r == ST_WR)
  `LRT_ASSERT_NEXT(a_ignored_word_stays_idle, start && !busy_r && !sts.pos_ok, !busy_r && !out_valid_r)

endmodule

FILE: hdl/longest_repeat_run_tracker.sv
`timescale 1ns / 1ps
// Busy from when a word is taken until it is done; D = depth of the written leaf is at most
// ceil(log2(length)). The strobe is in the first cycle with busy low, and the next word
// can be taken from that cycle on. The walk goes down D levels to the leaf, then each level
// up is a dual read of the node store, then merge and write back. A word at or beyond
// length is dropped at once.
// Synchronous active-low reset clears control and sets length to 1; tree nodes are not cleared.
module longest_repeat_run_tracker #(
  parameter int MAX_LENGTH = lrt_pkg::MAX_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lrt_pkg::LEN_W-1:0] cfg_length,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [lrt_pkg::POS_W-1:0] in_position,
  input  logic [lrt_pkg::SYM_W-1:0] in_symbol,
  output logic                      out_valid,
  output logic [lrt_pkg::LEN_W-1:0] out_longest_run
);
  import lrt_pkg::*;

  lrt_cmd_t cmd;
  lrt_sts_t sts;

  // Sequencer
  lrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Tree store, path stack and merge logic
  lrt_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_length      (cfg_length),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_symbol       (in_symbol),
    .cmd             (cmd),
    .sts             (sts),
    .out_longest_run (out_longest_run)
  );

endmodule
